[src/bced_pkg.sv]
`timescale 1ns / 1ps

package bced_pkg;

  // register indexes on the configuration port
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_PRESS_LEVEL  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SETTLE_TICKS = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_TICKS = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_TICKS   = 2'd3;

  // reset values of the registers
  localparam logic        RST_PRESS_LEVEL  = 1'b0;
  localparam logic [7:0]  RST_SETTLE_TICKS = 8'd3;
  localparam logic [15:0] RST_REPEAT_TICKS = 16'd0;
  localparam logic [15:0] RST_HOLD_TICKS   = 16'd0;

  // press phase codes
  localparam logic [1:0] PHASE_RELEASED = 2'd0;
  localparam logic [1:0] PHASE_HELD     = 2'd2;
  localparam logic [1:0] PHASE_PRESSED  = 2'd3;

  localparam logic [7:0]  PRESS_COUNT_MAX = 8'hFF;
  localparam logic [15:0] TICK_COUNT_MAX  = 16'hFFFF;

  typedef struct packed {
    logic        press_level;
    logic [7:0]  settle_ticks;
    logic [15:0] repeat_ticks;
    logic [15:0] hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic        stable_level;
    logic [7:0]  debounce_count;
    logic        was_pressed;
    logic [15:0] hold_count;
    logic [7:0]  press_count;
    logic [15:0] idle_count;
    logic [1:0]  press_phase;
    logic [7:0]  saved_click_count;
  } state_t;

  typedef struct packed {
    logic       press_down;
    logic       press_up;
    logic       long_hold;
    logic       release_settled;
    logic       single_click;
    logic       double_click;
    logic       multi_click;
    logic [7:0] last_click_count;
  } events_t;

endpackage

[src/button_click_event_detector_core.sv]
`timescale 1ns / 1ps

// button click event detector: takes one raw pin sample per input beat and
// returns one result beat per sample with the debounced press, release, long
// hold and click verdict events of that tick. a sample is registered on
// entry, then one pass of counter and compare logic updates the debounce and
// click state and fills the output register; a new sample can be taken every
// cycle (one sample per cycle sustained) while out_ready keeps the output
// register draining. the output register frees the input side while a
// result waits to be taken. configuration is written through cfg_we /
// cfg_index / cfg_data and should change only while no beat is in flight.
module button_click_event_detector_core (
  input  logic        clk,
  input  logic        rst,

  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,

  // sample input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        pin_raw,

  // event output
  output logic        out_valid,
  input  logic        out_ready,
  output logic        press_down,
  output logic        press_up,
  output logic        long_hold,
  output logic        release_settled,
  output logic        single_click,
  output logic        double_click,
  output logic        multi_click,
  output logic [7:0]  last_click_count
);

  bced_pkg::cfg_t    cfg;
  bced_pkg::state_t  st;
  bced_pkg::state_t  st_next;
  bced_pkg::events_t evt;
  bced_pkg::events_t out_evt;

  // input stage holds one sample
  logic s1_valid;
  logic s1_pin;

  logic out_free;
  logic s1_fire;

  // output register can take a new beat when empty or being drained
  assign out_free = !out_valid || out_ready;
  assign s1_fire  = s1_valid && out_free;
  assign in_ready = !s1_valid || out_free;

  bced_step u_step (
    .cfg     (cfg),
    .st      (st),
    .pin     (s1_pin),
    .st_next (st_next),
    .evt     (evt)
  );

  // control state, registers and detector state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid         <= 1'b0;
      out_valid        <= 1'b0;
      st               <= '0;
      cfg.press_level  <= bced_pkg::RST_PRESS_LEVEL;
      cfg.settle_ticks <= bced_pkg::RST_SETTLE_TICKS;
      cfg.repeat_ticks <= bced_pkg::RST_REPEAT_TICKS;
      cfg.hold_ticks   <= bced_pkg::RST_HOLD_TICKS;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bced_pkg::CFG_PRESS_LEVEL:  cfg.press_level  <= cfg_data[0];
          bced_pkg::CFG_SETTLE_TICKS: cfg.settle_ticks <= cfg_data[7:0];
          bced_pkg::CFG_REPEAT_TICKS: cfg.repeat_ticks <= cfg_data;
          bced_pkg::CFG_HOLD_TICKS:   cfg.hold_ticks   <= cfg_data;
          default: ;
        endcase
      end
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
      // state advances only when the sample moves into the output register
      if (s1_fire) begin
        st <= st_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_pin <= pin_raw;
    end
    if (s1_fire) begin
      out_evt <= evt;
    end
  end

  assign press_down       = out_evt.press_down;
  assign press_up         = out_evt.press_up;
  assign long_hold        = out_evt.long_hold;
  assign release_settled  = out_evt.release_settled;
  assign single_click     = out_evt.single_click;
  assign double_click     = out_evt.double_click;
  assign multi_click      = out_evt.multi_click;
  assign last_click_count = out_evt.last_click_count;

endmodule

[src/bced_step.sv]
`timescale 1ns / 1ps

// one tick of debounce and click tracking
module bced_step (
  input  bced_pkg::cfg_t    cfg,
  input  bced_pkg::state_t  st,
  input  logic              pin,
  output bced_pkg::state_t  st_next,
  output bced_pkg::events_t evt
);

  logic [8:0]  deb_inc;
  logic        deb_take;
  logic        level_next;
  logic        pressed;
  logic [15:0] hold_inc;

  assign deb_inc    = {1'b0, st.debounce_count} + 9'd1;
  assign deb_take   = (pin != st.stable_level) && (deb_inc >= {1'b0, cfg.settle_ticks});
  assign level_next = deb_take ? pin : st.stable_level;
  assign pressed    = (level_next == cfg.press_level);
  assign hold_inc   = (st.hold_count == bced_pkg::TICK_COUNT_MAX) ? st.hold_count
                                                                 : st.hold_count + 16'd1;

  always_comb begin
    st_next              = st;
    evt                  = '0;
    st_next.stable_level = level_next;
    st_next.was_pressed  = pressed;

    if (pin != st.stable_level && !deb_take) begin
      st_next.debounce_count = deb_inc[7:0];
    end else begin
      st_next.debounce_count = 8'd0;
    end

    if (pressed) begin
      if (!st.was_pressed) begin
        evt.press_down      = 1'b1;
        st_next.hold_count  = 16'd0;
        st_next.idle_count  = 16'd0;
        st_next.press_phase = bced_pkg::PHASE_PRESSED;
        if (st.press_count != bced_pkg::PRESS_COUNT_MAX) begin
          st_next.press_count = st.press_count + 8'd1;
        end
      end else begin
        st_next.hold_count  = hold_inc;
        st_next.press_phase = bced_pkg::PHASE_HELD;
        if (cfg.hold_ticks != 16'd0 && hold_inc >= cfg.hold_ticks) begin
          evt.long_hold      = 1'b1;
          st_next.hold_count = 16'd0;
        end
      end
    end else begin
      evt.press_up        = (st.press_phase != bced_pkg::PHASE_RELEASED);
      st_next.press_phase = bced_pkg::PHASE_RELEASED;
      if (st.idle_count < cfg.repeat_ticks) begin
        st_next.idle_count = st.idle_count + 16'd1;
      end else if (st.press_count != 8'd0) begin
        evt.release_settled = 1'b1;
        st_next.press_count = 8'd0;
        if (st.press_count == 8'd1) begin
          evt.single_click = 1'b1;
        end else if (st.press_count == 8'd2) begin
          evt.double_click = 1'b1;
        end else begin
          evt.multi_click           = 1'b1;
          st_next.saved_click_count = st.press_count;
        end
      end
    end

    evt.last_click_count = st_next.saved_click_count;
  end

endmodule

[src/bced_checker.sv]
`timescale 1ns / 1ps

module bced_assert_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       press_down,
  input logic       press_up,
  input logic       long_hold,
  input logic       release_settled,
  input logic       single_click,
  input logic       double_click,
  input logic       multi_click,
  input logic [7:0] last_click_count
);

  // at most one click verdict per beat
  a_one_verdict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0({single_click, double_click, multi_click}))
    else $error("more than one click verdict");

  // a verdict comes only with the settled event
  a_verdict_settled: assert property (@(posedge clk) disable iff (rst)
    out_valid && (single_click || double_click || multi_click) |-> release_settled)
    else $error("click verdict without settled event");

  // pressed-side and released-side events never share a beat
  a_sides_apart: assert property (@(posedge clk) disable iff (rst)
    out_valid && (press_down || long_hold) |-> !press_up && !release_settled)
    else $error("press and release events in one beat");

  // a stalled beat stays valid and holds its last click count and settled event
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(last_click_count)
      && $stable(release_settled))
    else $error("stalled beat changed");

endmodule

bind button_click_event_detector_core bced_assert_checker u_bced_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .press_down       (press_down),
  .press_up         (press_up),
  .long_hold        (long_hold),
  .release_settled  (release_settled),
  .single_click     (single_click),
  .double_click     (double_click),
  .multi_click      (multi_click),
  .last_click_count (last_click_count)
);
